FILE: rtl/lfp_pkg.sv
package lfp_pkg;

  localparam int SPEED_W  = 14;
  localparam int HITS_W   = 4;
  localparam int GAIN_W   = 8;
  localparam int DUTY_W   = 12;
  localparam int SERVO_W  = 7;
  localparam int MODE_W   = 2;
  localparam int WORD_W   = 16;
  localparam int FACTOR_W = 8;
  localparam int PROD_W   = SPEED_W + FACTOR_W;
  localparam int DEN_W    = 8;
  localparam int CNT_W    = 5;
  localparam int MAG_W    = 10;
  localparam int SCALED_W = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(WORD_W);
  localparam logic [4:0]       DUTY_SCALE = 5'd25;

  // x/100 == (x*PCT_RECIP) >> PCT_SHIFT for every x below 2^22
  localparam int                     PCT_RECIP_W = 22;
  localparam int                     PCT_SHIFT   = 28;
  localparam logic [PCT_RECIP_W-1:0] PCT_RECIP   = 22'd2684355;
  // x/60 == (x*DRIVE_RECIP) >> DRIVE_SHIFT for every 16-bit x
  localparam int                       DRIVE_RECIP_W = 16;
  localparam int                       DRIVE_SHIFT   = 21;
  localparam logic [DRIVE_RECIP_W-1:0] DRIVE_RECIP   = 16'd34953;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_P_GAIN       = 3'd0,
    CFG_I_DIVISOR    = 3'd1,
    CFG_D_GAIN       = 3'd2,
    CFG_DUTY_FLOOR   = 3'd3,
    CFG_DUTY_CEILING = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] p_gain;
    logic [GAIN_W-1:0] i_divisor;
    logic [GAIN_W-1:0] d_gain;
    logic [DUTY_W-1:0] duty_floor;
    logic [DUTY_W-1:0] duty_ceiling;
  } cfg_t;

  typedef struct packed {
    logic [SPEED_W-1:0] base_speed;
    logic [SPEED_W-1:0] left_measured;
    logic [SPEED_W-1:0] right_measured;
    logic [HITS_W-1:0]  right_hits;
    logic [HITS_W-1:0]  left_hits;
    logic               centered;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  left_fwd_duty;
    logic [DUTY_W-1:0]  left_rev_duty;
    logic [DUTY_W-1:0]  right_fwd_duty;
    logic [DUTY_W-1:0]  right_rev_duty;
    logic [SERVO_W-1:0] servo_compare;
    logic [MODE_W-1:0]  steer_mode;
  } out_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] fwd;
    logic [DUTY_W-1:0] rev;
  } lane_res_t;

  typedef struct packed {
    logic [SERVO_W-1:0] servo;
    logic [MODE_W-1:0]  mode;
  } steer_res_t;

  // which sensor won the priority pick
  typedef enum logic [3:0] {
    SC_NONE, SC_R1, SC_R2, SC_R3, SC_R4, SC_L1, SC_L2, SC_L3, SC_L4
  } steer_code_t;

  // 100 + rate
  function automatic logic [FACTOR_W-1:0] left_factor(steer_code_t c);
    case (c)
      SC_R4:   return 8'd140;
      SC_R3:   return 8'd108;
      SC_R2:   return 8'd104;
      SC_R1:   return 8'd102;
      SC_L1:   return 8'd98;
      SC_L2:   return 8'd96;
      SC_L3:   return 8'd92;
      SC_L4:   return 8'd60;
      default: return 8'd100;
    endcase
  endfunction

  // 100 - rate
  function automatic logic [FACTOR_W-1:0] right_factor(steer_code_t c);
    case (c)
      SC_R4:   return 8'd60;
      SC_R3:   return 8'd92;
      SC_R2:   return 8'd96;
      SC_R1:   return 8'd98;
      SC_L1:   return 8'd102;
      SC_L2:   return 8'd104;
      SC_L3:   return 8'd108;
      SC_L4:   return 8'd140;
      default: return 8'd100;
    endcase
  endfunction

  // servo compare per angle, negative angles already floor-halved
  function automatic logic [SERVO_W-1:0] servo_of(steer_code_t c);
    case (c)
      SC_R4:   return 7'd76;
      SC_R3:   return 7'd54;
      SC_R2:   return 7'd50;
      SC_R1:   return 7'd48;
      SC_L1:   return 7'd45;
      SC_L2:   return 7'd44;
      SC_L3:   return 7'd41;
      SC_L4:   return 7'd30;
      default: return 7'd46;
    endcase
  endfunction

endpackage

FILE: rtl/lfp_div.sv
module lfp_div
  import lfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] num,
  input  logic [DEN_W-1:0]  den,
  output logic              done,
  output logic [WORD_W-1:0] quot
);

  logic [WORD_W-1:0] dq_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic [DEN_W:0]    trial;
  logic              qbit;

  assign trial = {rem_r, dq_r[WORD_W-1]};
  assign qbit  = (trial >= {1'b0, den_r});
  assign done  = busy_r && (cnt_r == '0);
  assign quot  = dq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_STEPS;
      rem_r  <= '0;
      den_r  <= den;
      dq_r   <= num;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
        rem_r <= qbit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        dq_r  <= {dq_r[WORD_W-2:0], qbit};
      end
    end
  end

endmodule

FILE: rtl/lfp_lane.sv
module lfp_lane
  import lfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SPEED_W-1:0]  speed,
  input  logic [FACTOR_W-1:0] factor,
  input  logic [SPEED_W-1:0]  measured,
  input  cfg_t                cfg,
  output logic                done,
  output lane_res_t           res
);

  typedef enum logic [3:0] {
    L_IDLE, L_MUL, L_TGT, L_ERR, L_PD, L_IDIV, L_SUM, L_DDIV, L_DUTY, L_DONE
  } lane_state_t;

  lane_state_t state_r;

  logic [SPEED_W-1:0]  speed_r;
  logic [FACTOR_W-1:0] factor_r;
  logic [SPEED_W-1:0]  meas_r;
  logic [PROD_W-1:0]   prod_r;
  logic [WORD_W-1:0]   sum_r;
  logic [WORD_W-1:0]   prev_r;
  logic [WORD_W-1:0]   err_r;
  logic [WORD_W-1:0]   acc_r;
  logic [WORD_W-1:0]   diff_r;
  logic [WORD_W-1:0]   pterm_r;
  logic [WORD_W-1:0]   dterm_r;
  logic [WORD_W-1:0]   iterm_r;
  logic [WORD_W-1:0]   dmag_r;
  logic                acc_neg_r;
  logic                drv_neg_r;
  logic [MAG_W-1:0]    mag_r;
  lane_res_t           res_r;

  logic              div_start;
  logic [WORD_W-1:0] div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_done;
  logic [WORD_W-1:0] div_quot;

  logic [WORD_W-1:0]                 acc_mag;
  logic [WORD_W-1:0]                 drive;
  logic [WORD_W-1:0]                 drive_mag;
  logic [2*WORD_W-1:0]               pprod;
  logic [2*WORD_W-1:0]               dprod;
  logic [PROD_W+PCT_RECIP_W-1:0]     tgt_prod;
  logic [WORD_W+DRIVE_RECIP_W-1:0]   quo_prod;
  logic [SCALED_W-1:0]               scaled;
  logic [DUTY_W-1:0]                 clamped;
  logic                              rev_dir;

  assign acc_mag   = acc_r[WORD_W-1] ? WORD_W'(-acc_r) : acc_r;
  assign drive     = pterm_r + iterm_r + dterm_r;
  assign drive_mag = drive[WORD_W-1] ? WORD_W'(-drive) : drive;
  // low 16 bits of the product do not depend on operand signedness
  assign pprod     = (2*WORD_W)'(cfg.p_gain) * (2*WORD_W)'(err_r);
  assign dprod     = (2*WORD_W)'(cfg.d_gain) * (2*WORD_W)'(diff_r);
  assign tgt_prod  = (PROD_W+PCT_RECIP_W)'(prod_r) * (PROD_W+PCT_RECIP_W)'(PCT_RECIP);
  assign quo_prod  = (WORD_W+DRIVE_RECIP_W)'(dmag_r) * (WORD_W+DRIVE_RECIP_W)'(DRIVE_RECIP);
  assign scaled    = SCALED_W'(mag_r) * SCALED_W'(DUTY_SCALE);
  assign rev_dir   = drv_neg_r && (mag_r != '0);

  always_comb begin
    if (scaled < SCALED_W'(cfg.duty_floor)) begin
      clamped = cfg.duty_floor;
    end else if (scaled > SCALED_W'(cfg.duty_ceiling)) begin
      clamped = cfg.duty_ceiling;
    end else begin
      clamped = scaled[DUTY_W-1:0];
    end
  end

  // serial divide only for the integral term
  assign div_start = (state_r == L_PD) && (cfg.i_divisor != '0);
  assign div_num   = acc_mag;
  assign div_den   = cfg.i_divisor;

  lfp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (div_num),
    .den      (div_den),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      sum_r   <= '0;
      prev_r  <= '0;
    end else begin
      case (state_r)
        L_IDLE, L_DONE: begin
          if (start) begin
            speed_r  <= speed;
            factor_r <= factor;
            meas_r   <= measured;
            state_r  <= L_MUL;
          end
        end
        L_MUL: begin
          prod_r  <= PROD_W'(speed_r) * PROD_W'(factor_r);
          state_r <= L_TGT;
        end
        L_TGT: begin
          err_r   <= tgt_prod[PCT_SHIFT +: WORD_W] - WORD_W'(meas_r);
          state_r <= L_ERR;
        end
        L_ERR: begin
          acc_r   <= sum_r + err_r;
          diff_r  <= err_r - prev_r;
          state_r <= L_PD;
        end
        L_PD: begin
          pterm_r   <= pprod[WORD_W-1:0];
          dterm_r   <= dprod[WORD_W-1:0];
          acc_neg_r <= acc_r[WORD_W-1];
          iterm_r   <= '0;
          state_r   <= (cfg.i_divisor != '0) ? L_IDIV : L_SUM;
        end
        L_IDIV: begin
          if (div_done) begin
            iterm_r <= acc_neg_r ? WORD_W'(-div_quot) : div_quot;
            state_r <= L_SUM;
          end
        end
        L_SUM: begin
          drv_neg_r <= drive[WORD_W-1];
          dmag_r    <= drive_mag;
          sum_r     <= acc_r;
          prev_r    <= err_r;
          state_r   <= L_DDIV;
        end
        L_DDIV: begin
          mag_r   <= quo_prod[DRIVE_SHIFT +: MAG_W];
          state_r <= L_DUTY;
        end
        L_DUTY: begin
          res_r.fwd <= rev_dir ? '0 : clamped;
          res_r.rev <= rev_dir ? clamped : '0;
          state_r   <= L_DONE;
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign done = (state_r == L_DONE);
  assign res  = res_r;

endmodule

FILE: rtl/lfp_steer.sv
module lfp_steer
  import lfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [HITS_W-1:0]   right_hits,
  input  logic [HITS_W-1:0]   left_hits,
  input  logic                centered,
  output logic [FACTOR_W-1:0] left_fac,
  output logic [FACTOR_W-1:0] right_fac,
  output steer_res_t          res
);

  typedef enum logic [MODE_W-1:0] {
    MODE_TRACK      = 2'd0,
    MODE_HARD_RIGHT = 2'd1,
    MODE_HARD_LEFT  = 2'd2
  } mode_t;

  mode_t              state_r;
  mode_t              state_nxt;
  logic [SERVO_W-1:0] servo_r;
  steer_code_t        code;

  always_comb begin
    code      = SC_NONE;
    state_nxt = MODE_TRACK;
    case (state_r)
      MODE_HARD_RIGHT: begin
        if (left_hits == '0) begin
          code      = SC_R4;
          state_nxt = MODE_HARD_RIGHT;
        end
      end
      MODE_HARD_LEFT: begin
        if (right_hits == '0) begin
          code      = SC_L4;
          state_nxt = MODE_HARD_LEFT;
        end
      end
      default: begin
        if (centered)          code = SC_NONE;
        else if (right_hits[3]) begin
          code      = SC_R4;
          state_nxt = MODE_HARD_RIGHT;
        end
        else if (right_hits[2]) code = SC_R3;
        else if (right_hits[1]) code = SC_R2;
        else if (right_hits[0]) code = SC_R1;
        else if (left_hits[3]) begin
          code      = SC_L4;
          state_nxt = MODE_HARD_LEFT;
        end
        else if (left_hits[2]) code = SC_L3;
        else if (left_hits[1]) code = SC_L2;
        else if (left_hits[0]) code = SC_L1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MODE_TRACK;
      servo_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
      servo_r <= servo_of(code);
    end
  end

  assign left_fac   = left_factor(code);
  assign right_fac  = right_factor(code);
  assign res.servo  = servo_r;
  assign res.mode   = state_r;

endmodule

FILE: rtl/line_follow_dual_wheel_pid_top.sv
// Channel  Ports                            Payload      Direction
// in       in_valid  in_ready  in_data       in_item_t    into block
// out      out_valid out_ready out_data      out_item_t   out of block
// cfg      cfg_valid cfg_ready cfg_index     cfg_data     into block
//
// One request at a time. The integral term takes a 16-step serial divide in each
// wheel lane, skipped when i_divisor is zero; the percent split and the final /60
// are reciprocal multiplies. Both lanes run side by side.
// Synchronous active-low reset restores register defaults and clears PID state.
// A result waiting on out_ready does not block the next request.
module line_follow_dual_wheel_pid_top
  import lfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t          cfg_r;
  logic          busy_r;
  logic          out_valid_r;
  out_item_t     out_r;

  logic          accept;
  logic          merge;
  logic [FACTOR_W-1:0] lfac;
  logic [FACTOR_W-1:0] rfac;
  steer_res_t    steer_res;
  logic          left_done;
  logic          right_done;
  lane_res_t     left_res;
  lane_res_t     right_res;

  assign in_ready  = !busy_r;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign merge     = busy_r && left_done && right_done && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.p_gain       <= 8'd2;
      cfg_r.i_divisor    <= 8'd2;
      cfg_r.d_gain       <= 8'd4;
      cfg_r.duty_floor   <= 12'd1250;
      cfg_r.duty_ceiling <= 12'd1700;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_P_GAIN:       cfg_r.p_gain       <= cfg_data[GAIN_W-1:0];
        CFG_I_DIVISOR:    cfg_r.i_divisor    <= cfg_data[GAIN_W-1:0];
        CFG_D_GAIN:       cfg_r.d_gain       <= cfg_data[GAIN_W-1:0];
        CFG_DUTY_FLOOR:   cfg_r.duty_floor   <= cfg_data;
        CFG_DUTY_CEILING: cfg_r.duty_ceiling <= cfg_data;
        default: ;
      endcase
    end
  end

  lfp_steer u_steer (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .right_hits (in_data.right_hits),
    .left_hits  (in_data.left_hits),
    .centered   (in_data.centered),
    .left_fac   (lfac),
    .right_fac  (rfac),
    .res        (steer_res)
  );

  lfp_lane u_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .speed    (in_data.base_speed),
    .factor   (lfac),
    .measured (in_data.left_measured),
    .cfg      (cfg_r),
    .done     (left_done),
    .res      (left_res)
  );

  lfp_lane u_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .speed    (in_data.base_speed),
    .factor   (rfac),
    .measured (in_data.right_measured),
    .cfg      (cfg_r),
    .done     (right_done),
    .res      (right_res)
  );

  // merge stage: both lanes plus steering into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end else if (merge) begin
        busy_r <= 1'b0;
      end
      if (merge) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (merge) begin
      out_r.left_fwd_duty  <= left_res.fwd;
      out_r.left_rev_duty  <= left_res.rev;
      out_r.right_fwd_duty <= right_res.fwd;
      out_r.right_rev_duty <= right_res.rev;
      out_r.servo_compare  <= steer_res.servo;
      out_r.steer_mode     <= steer_res.mode;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/lfp_chk.sv
module lfp_chk
  import lfp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input in_item_t              in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input out_item_t             out_data,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.left_fwd_duty == '0 || out_data.left_rev_duty == '0) &&
                  (out_data.right_fwd_duty == '0 || out_data.right_rev_duty == '0))
    else $error("both directions driven on one wheel");

  a_mode_servo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.steer_mode == 2'd1 |-> out_data.servo_compare == 7'd76)
    else $error("hard right without full right servo");

  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.steer_mode != 2'd3 &&
                  out_data.servo_compare >= 7'd30 && out_data.servo_compare <= 7'd76)
    else $error("steer result out of range");

endmodule

bind line_follow_dual_wheel_pid_top lfp_chk u_chk (.*);
